// File: hdl/sst_pkg.sv
package sst_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int TOTAL_BITS  = SAMPLE_BITS + COUNT_BITS;
  localparam int STEP_BITS   = $clog2(TOTAL_BITS);

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [STEP_BITS-1:0]   LAST_STEP  = STEP_BITS'(TOTAL_BITS - 1);

  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_STOP   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic start_clr;
    logic take_sample;
    logic zero_stop;
    logic div_init;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic div_last;
  } dp_status_t;

endpackage

// File: hdl/sst_ctrl.sv
module sst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sst_pkg::dp_status_t status_i,
  output sst_pkg::ctrl_cmd_t  cmd_o
);

  sst_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sst_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    accept      = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      sst_pkg::ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        accept     = in_ready_o && in_valid_i;
        if (accept) begin
          state_d = sst_pkg::ST_EMIT;
          case (func_i)
            sst_pkg::FUNC_START: cmd_o.start_clr = 1'b1;
            sst_pkg::FUNC_SAMPLE: cmd_o.take_sample = 1'b1;
            sst_pkg::FUNC_STOP: begin
              if (status_i.count_zero) begin
                cmd_o.zero_stop = 1'b1;
              end else begin
                cmd_o.div_init = 1'b1;
                state_d        = sst_pkg::ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      sst_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = sst_pkg::ST_EMIT;
        end
      end
      sst_pkg::ST_EMIT: begin
        cmd_o.load_out = 1'b1;
        out_valid_d    = 1'b1;
        state_d        = sst_pkg::ST_IDLE;
      end
      default: state_d = sst_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/sst_datapath.sv
module sst_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sst_pkg::ctrl_cmd_t                cmd_i,
  input  logic [sst_pkg::SAMPLE_BITS-1:0]   sample_i,
  output sst_pkg::dp_status_t               status_o,
  output logic                              stats_valid_o,
  output logic [sst_pkg::COUNT_BITS-1:0]    sample_count_o,
  output logic [sst_pkg::SAMPLE_BITS-1:0]   average_o,
  output logic [sst_pkg::SAMPLE_BITS-1:0]   maximum_o,
  output logic [sst_pkg::SAMPLE_BITS-1:0]   minimum_o,
  output logic [sst_pkg::SAMPLE_BITS-1:0]   smoothed_o,
  output logic                              zero_count_error_o
);

  localparam int SB = sst_pkg::SAMPLE_BITS;
  localparam int CB = sst_pkg::COUNT_BITS;
  localparam int TB = sst_pkg::TOTAL_BITS;

  logic                              running_q;
  logic [CB-1:0]                     count_q;
  logic [TB-1:0]                     total_q;
  logic [SB-1:0]                     largest_q;
  logic [SB-1:0]                     smallest_q;
  logic [SB-1:0]                     filtered_q;
  logic [SB-1:0]                     mean_q;
  logic                              empty_q;
  logic [CB-1:0]                     rem_q;
  logic [TB-1:0]                     quo_q;
  logic [sst_pkg::STEP_BITS-1:0]     step_q;

  logic [SB+1:0]                     filt_sum;
  logic [SB-1:0]                     filt_d;
  logic [CB:0]                       trial;
  logic                              fits;
  logic [CB:0]                       diff;
  logic [TB-1:0]                     quo_d;

  always_comb begin
    if (sample_i >= filtered_q) begin
      filt_sum = {2'b00, filtered_q} + {1'b0, sample_i, 1'b0} + {2'b00, sample_i};
    end else begin
      filt_sum = {1'b0, filtered_q, 1'b0} + {2'b00, filtered_q} + {2'b00, sample_i};
    end
    if (filtered_q == '0) begin
      filt_d = sample_i;
    end else begin
      filt_d = filt_sum[SB+1:2];
    end
    trial = {rem_q, quo_q[TB-1]};
    fits  = trial >= {1'b0, count_q};
    diff  = trial - {1'b0, count_q};
    quo_d = {quo_q[TB-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      count_q    <= '0;
      total_q    <= '0;
      largest_q  <= '0;
      smallest_q <= sst_pkg::SAMPLE_MAX;
      filtered_q <= '0;
      mean_q     <= '0;
      empty_q    <= 1'b0;
      rem_q      <= '0;
      quo_q      <= '0;
      step_q     <= '0;
    end else begin
      if (cmd_i.start_clr) begin
        running_q  <= 1'b1;
        count_q    <= '0;
        total_q    <= '0;
        largest_q  <= '0;
        smallest_q <= sst_pkg::SAMPLE_MAX;
        filtered_q <= '0;
        mean_q     <= '0;
        empty_q    <= 1'b0;
      end
      if (cmd_i.take_sample && running_q) begin
        if (count_q != sst_pkg::COUNT_MAX) begin
          count_q <= count_q + 1'b1;
          total_q <= total_q + TB'(sample_i);
        end
        if (sample_i > largest_q) begin
          largest_q <= sample_i;
        end
        if (sample_i < smallest_q) begin
          smallest_q <= sample_i;
        end
        filtered_q <= filt_d;
      end
      if (cmd_i.zero_stop) begin
        running_q <= 1'b0;
        mean_q    <= '0;
        empty_q   <= 1'b1;
      end
      if (cmd_i.div_init) begin
        running_q <= 1'b0;
        rem_q     <= '0;
        quo_q     <= total_q;
        step_q    <= '0;
      end
      if (cmd_i.div_step) begin
        rem_q  <= fits ? diff[CB-1:0] : trial[CB-1:0];
        quo_q  <= quo_d;
        step_q <= step_q + 1'b1;
        if (step_q == sst_pkg::LAST_STEP) begin
          mean_q  <= quo_d[SB-1:0];
          empty_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      stats_valid_o      <= !running_q;
      sample_count_o     <= count_q;
      average_o          <= mean_q;
      maximum_o          <= largest_q;
      minimum_o          <= smallest_q;
      smoothed_o         <= filtered_q;
      zero_count_error_o <= empty_q;
    end
  end

  assign status_o.count_zero = count_q == '0;
  assign status_o.div_last   = step_q == sst_pkg::LAST_STEP;

endmodule

// File: hdl/sample_statistics_tracker.sv
// Channel   Dir  Handshake                 Contents
// s_axis    in   tvalid / tready           tuser = func, tdata = sample
// m_axis    out  tvalid / tready           tuser = flags, tdata = statistics
//
// Start, sample and unused codes: the statistics update at the accepting edge,
// then ST_EMIT loads the result word into the output register.
// A stop with samples first runs the bit-serial restoring divider in ST_DIV.
// Reset clears the statistics, disarms the block and clears the output valid; the output data is not reset.
// A new word is taken while the previous result is being taken in the same cycle.
module sample_statistics_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] sample
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // sample_count, average, maximum, minimum, smoothed
  output logic [1:0]  m_axis_tuser_o    // [0] stats_valid, [1] zero_count_error
);

  sst_pkg::ctrl_cmd_t  cmd;
  sst_pkg::dp_status_t status;

  sst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .func_i      (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sst_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sample_i           (s_axis_tdata_i),
    .status_o           (status),
    .stats_valid_o      (m_axis_tuser_o[0]),
    .sample_count_o     (m_axis_tdata_o[15:0]),
    .average_o          (m_axis_tdata_o[31:16]),
    .maximum_o          (m_axis_tdata_o[47:32]),
    .minimum_o          (m_axis_tdata_o[63:48]),
    .smoothed_o         (m_axis_tdata_o[79:64]),
    .zero_count_error_o (m_axis_tuser_o[1])
  );

endmodule

// File: hdl/sst_checker.sv
module sst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input word accepted in two consecutive cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result word changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tdata_o[31:16] == 16'd0)
    else $error("zero count error with nonzero average");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> !m_axis_tuser_o[1])
    else $error("zero count error shown while armed");

endmodule

bind sample_statistics_tracker sst_checker u_sst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
